>>> sv/psf_pkg.sv
// Shared types and constants for the per-source sequence filter.
// Used by psf_ctrl and per_source_sequence_filter; no dependencies.

package psf_pkg;

    localparam int SRC_W     = 16;
    localparam int SEQ_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DAT_W  = 32;
    localparam int OUT_DAT_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LOW  = 8'd1;

    localparam logic [SEQ_W-1:0] WRAP_HIGH_RST = 16'd61440;
    localparam logic [SEQ_W-1:0] WRAP_LOW_RST  = 16'd4096;

    // One table entry as stored in the RAM word.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [SRC_W-1:0] src;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [SEQ_W-1:0] high;
        logic [SEQ_W-1:0] low;
    } t_thresh;

    typedef struct packed {
        logic table_full;
        logic accept;
    } t_result;

endpackage

>>> sv/psf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module psf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/psf_ctrl.sv
// Search-and-update sequencer: scans the source table one entry per cycle
// through a shared compare unit. Depends on psf_pkg and psf_ram.

module psf_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_src,
    input  logic [15:0]        i_seq,
    input  psf_pkg::t_thresh   i_thresh,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output psf_pkg::t_result   o_res
);

    import psf_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SRC_W-1:0]    r_src, n_src;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    t_result             r_res, n_res;

    logic                issuing;
    logic                hit;
    logic                fresher;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    t_entry              wdata;
    t_entry              rd_entry;
    logic [ENTRY_W-1:0]  rd_word;

    psf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issuing),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (rd_word)
    );

    assign rd_entry = t_entry'(rd_word);

    // A read is issued every cycle while unsearched entries remain; the
    // compare works on the entry read in the previous cycle.
    assign issuing = (r_state == ST_SCAN) && (r_issue < r_count);
    assign hit     = r_pend && (rd_entry.src == r_src);
    assign fresher = (r_seq > rd_entry.seq) ||
                     ((rd_entry.seq > i_thresh.high) && (r_seq < i_thresh.low));

    always_comb begin
        n_state    = r_state;
        n_src      = r_src;
        n_seq      = r_seq;
        n_issue    = r_issue;
        n_count    = r_count;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_res      = r_res;
        we         = 1'b0;
        waddr      = r_pend_idx;
        wdata      = '{seq: r_seq, src: r_src};
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_src   = i_src;
                    n_seq   = i_seq;
                    n_issue = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_pend     = issuing;
                n_pend_idx = r_issue[IDX_W-1:0];
                if (issuing) begin
                    n_issue = r_issue + 1'b1;
                end
                if (hit) begin
                    we      = fresher;
                    waddr   = r_pend_idx;
                    n_res   = '{table_full: 1'b0, accept: fresher};
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                end else if (!issuing) begin
                    // Whole table searched without a match: new source.
                    if (r_count < CNT_W'(TABLE_DEPTH)) begin
                        we      = 1'b1;
                        waddr   = r_count[IDX_W-1:0];
                        n_count = r_count + 1'b1;
                        n_res   = '{table_full: 1'b0, accept: 1'b1};
                    end else begin
                        n_res   = '{table_full: 1'b1, accept: 1'b1};
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_src      <= n_src;
        r_seq      <= n_seq;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

>>> sv/per_source_sequence_filter.sv
// Top level of the per-source sequence filter: configuration registers,
// output register and the search sequencer. Depends on psf_pkg, psf_ctrl.
//
//  Channel   Direction  Ports                          Contents
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata  source_addr, seq_value
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata  accept, table_full
//  cfg       in         i_cfg_valid/o_cfg_ready          register index and data
//
// With n entries in the table, a new source is compared against all n entries
// before its result goes to the output register, and a match at entry j ends
// the search there. The table RAM reads one entry per cycle into one shared
// compare unit, and the input is ready again once the sequencer is idle.
// Reset clears the entry count and output valid and loads default thresholds;
// the table RAM needs no clearing. The input is taken again once the result has
// left the sequencer, even if the output register still waits for i_m_tready.

module per_source_sequence_filter #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [psf_pkg::IN_DAT_W-1:0]  i_s_tdata,   // [15:0] source_addr, [31:16] seq_value
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [psf_pkg::OUT_DAT_W-1:0] o_m_tdata,   // [0] accept, [1] table_full, [7:2] zero
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psf_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    import psf_pkg::*;

    t_thresh r_thresh;
    logic    r_m_valid;
    t_result r_m_res;
    logic    out_free;
    logic    res_valid;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.high <= WRAP_HIGH_RST;
            r_thresh.low  <= WRAP_LOW_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WRAP_HIGH) begin
                r_thresh.high <= i_cfg_data;
            end else if (i_cfg_index == REG_WRAP_LOW) begin
                r_thresh.low <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    psf_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_src       (i_s_tdata[15:0]),
        .i_seq       (i_s_tdata[31:16]),
        .i_thresh    (r_thresh),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res)
    );

    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= res_valid;
        end
        if (out_free && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_m_res.table_full, r_m_res.accept};

endmodule
